// ----- hdl/light_to_tone_sine_synth_assert.svh -----
// Assertion macros for the light-to-tone sine synthesizer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIGHT_TO_TONE_SINE_SYNTH_ASSERT_SVH
`define LIGHT_TO_TONE_SINE_SYNTH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LTTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ltts_pkg.sv -----
// Shared types, constants and the quarter-wave sine function of the light-to-tone synthesizer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ltts_pkg;

    // Field widths of the ports.
    localparam int LUX_W      = 16;
    localparam int FREQ_W     = 20;
    localparam int SCALE_W    = 28;
    localparam int AMP_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int SINE_W     = 15;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_INDEX_W = 3;

    // Internal datapath widths. Lux below either limit fits in 14 bits.
    localparam int XW      = 14;
    localparam int C3_W    = 27;
    localparam int C2_W    = 39;
    localparam int C1_W    = 50;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int V_W     = 42;
    localparam int VLO_W   = 28;
    localparam int ACC_W   = 56;
    localparam int U_W     = 57;
    localparam int U_SHIFT = 20;
    localparam int Q_W     = 32;
    localparam int POLY_SHIFT = 24;
    localparam int POLY_W  = 22;
    localparam int PSUM_W  = POLY_W + POLY_SHIFT;
    localparam int FSUM_W  = POLY_W + 1;
    localparam int STEP_TOP = FREQ_W + SCALE_W - 1;
    localparam int GAIN_SHIFT = 15;
    localparam int GSUM_W  = SINE_W + AMP_W + 1;

    // Cubic coefficients scaled by 2^52, indoor and outdoor curves.
    localparam logic [C3_W-1:0] IN_C3  = 27'd111780677;
    localparam logic [C2_W-1:0] IN_C2  = 39'd317694569085;
    localparam logic [C1_W-1:0] IN_C1  = 50'd619767890548745;
    localparam logic [C3_W-1:0] OUT_C3 = 27'd13972585;
    localparam logic [C2_W-1:0] OUT_C2 = 39'd79423642271;
    localparam logic [C1_W-1:0] OUT_C1 = 50'd309883945274372;
    localparam logic [LUX_W-1:0] IN_LIMIT  = 16'd5000;
    localparam logic [LUX_W-1:0] OUT_LIMIT = 16'd10000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 20'hFFFFF;

    // Register reset values.
    localparam logic [FREQ_W-1:0]  BASE_FREQ_RST    = 20'd33488;
    localparam logic [FREQ_W-1:0]  CEILING_FREQ_RST = 20'd535847;
    localparam logic [SCALE_W-1:0] PHASE_SCALE_RST  = 28'd22906492;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST    = 15'd16384;

    // Sine series constants in Q2.30.
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint ONE_Q30    = 64'sd1073741824;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OUTDOOR_MODE,
        REG_BASE_FREQ,
        REG_CEILING_FREQ,
        REG_PHASE_SCALE,
        REG_AMPLITUDE,
        REG_WAVE_ENABLE
    } cfg_reg_t;

    typedef struct packed {
        logic                outdoor_mode;
        logic [FREQ_W-1:0]   base_freq;
        logic [FREQ_W-1:0]   ceiling_freq;
        logic [SCALE_W-1:0]  phase_scale;
        logic [AMP_W-1:0]    amplitude;
        logic                wave_enable;
    } cfg_t;

    // Payload of one request on each channel.
    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             end_of_block;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [FREQ_W-1:0]          tone_freq;
        logic                       last_in_block;
    } tone_t;

    // Controller states, one per datapath step.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C3X,
        ST_VDIFF,
        ST_VLO,
        ST_VHI,
        ST_SUMW,
        ST_SUMU,
        ST_QX,
        ST_FREQ,
        ST_MSTEP,
        ST_STEP,
        ST_GAIN,
        ST_OUT
    } state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_C3X,
        OP_VDIFF,
        OP_MUL_VLO,
        OP_MUL_VHI,
        OP_SUM_W,
        OP_SUM_U,
        OP_MUL_QX,
        OP_FREQ,
        OP_MUL_STEP,
        OP_STEP,
        OP_MUL_GAIN,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    // Truncating quotient of two non-negative values by shift and subtract.
    // Used only while the constant sine table is built.
    function automatic longint long_quotient(input longint num, input longint den);
        longint quo;
        longint rem;
        int     b;
        quo = 0;
        rem = 0;
        for (b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (longint'(1) <<< b);
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine entry q of a 2^addr_bits table, rounded to Q1.15.
    // Evaluated only at elaboration to build the constant table.
    function automatic logic [SINE_W-1:0] quarter_sine(input int q, input int addr_bits);
        longint x;
        longint x2;
        longint term;
        longint acc;
        longint scaled;
        int     n;
        x = (longint'(q) * TWO_PI_Q30 + (longint'(1) <<< (addr_bits - 1))) >>> addr_bits;
        x2 = (x * x) >>> 30;
        term = x;
        acc = x;
        for (n = 1; n <= 8; n++) begin
            term = (term * x2) >>> 30;
            term = long_quotient(term, longint'((2 * n) * (2 * n + 1)));
            if (n[0]) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        scaled = (acc * 64'sd32767 + (longint'(1) <<< 29)) >>> 30;
        return scaled[SINE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/light_to_tone_sine_synth.sv -----
// Top level of the light-to-tone sine synthesizer: configuration registers,
// controller and datapath. Depends on ltts_pkg, ltts_cfg, ltts_ctrl and ltts_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each frame request carries a lux reading; the block turns it into a tone
// frequency (cubic curve plus base offset, or the ceiling above the mode's lux
// limit), a phase increment, and one signed Q1.15 sine sample from the phase
// accumulator, returned with the frequency and the end-of-block flag. A frame
// is accepted only while the block is idle; its result is loaded into the
// output register in ST_OUT after the steps ST_C3X through ST_GAIN, and no new
// frame is taken before that. The single 32 x 28 multiplier forms the six
// products of each frame one after another. A finished result waits in the
// output register while the next frame is already accepted; only when a second
// result is ready before the first has been taken does the block stall. The
// sine table is constant logic, so there is no start-up fill after reset.
// Configuration writes take effect at once and should be made while idle.
module light_to_tone_sine_synth #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             frame_valid,
    output logic                                  frame_ready,
    input  wire ltts_pkg::frame_t                 frame,
    output logic                                  tone_valid,
    input  wire logic                             tone_ready,
    output ltts_pkg::tone_t                       tone,
    input  wire logic                             cfg_we,
    input  wire logic [ltts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ltts_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ltts_pkg::cfg_t       cfg;
    ltts_pkg::dp_cmd_t    cmd;
    ltts_pkg::dp_status_t status;

    // Register file.
    ltts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Step sequencer.
    ltts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .cmd         (cmd),
        .status      (status)
    );

    // Arithmetic, phase and output register.
    ltts_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg),
        .frame      (frame),
        .tone       (tone),
        .tone_valid (tone_valid),
        .tone_ready (tone_ready)
    );

endmodule

`default_nettype wire

// ----- hdl/ltts_cfg.sv -----
// Configuration register file of the light-to-tone synthesizer.
// Depends on ltts_pkg for the register indexes, reset values and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module ltts_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ltts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ltts_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ltts_pkg::cfg_t                          cfg
);

    ltts_pkg::cfg_t cfg_reg;
    ltts_pkg::cfg_t cfg_next;

    // Write decode: each register takes the low bits of the data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ltts_pkg::REG_OUTDOOR_MODE: cfg_next.outdoor_mode = cfg_data[0];
                ltts_pkg::REG_BASE_FREQ:    cfg_next.base_freq = cfg_data[ltts_pkg::FREQ_W-1:0];
                ltts_pkg::REG_CEILING_FREQ:
                    cfg_next.ceiling_freq = cfg_data[ltts_pkg::FREQ_W-1:0];
                ltts_pkg::REG_PHASE_SCALE:
                    cfg_next.phase_scale = cfg_data[ltts_pkg::SCALE_W-1:0];
                ltts_pkg::REG_AMPLITUDE:    cfg_next.amplitude = cfg_data[ltts_pkg::AMP_W-1:0];
                ltts_pkg::REG_WAVE_ENABLE:  cfg_next.wave_enable = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outdoor_mode <= 1'b0;
            cfg_reg.base_freq    <= ltts_pkg::BASE_FREQ_RST;
            cfg_reg.ceiling_freq <= ltts_pkg::CEILING_FREQ_RST;
            cfg_reg.phase_scale  <= ltts_pkg::PHASE_SCALE_RST;
            cfg_reg.amplitude    <= ltts_pkg::AMPLITUDE_RST;
            cfg_reg.wave_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/ltts_ctrl.sv -----
// Sequencing state machine of the light-to-tone synthesizer.
// Depends on ltts_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ltts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               frame_valid,
    output logic                    frame_ready,
    output ltts_pkg::dp_cmd_t       cmd,
    input  wire ltts_pkg::dp_status_t status
);

    ltts_pkg::state_t state_reg;
    ltts_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and one datapath operation per state.
    always_comb
    begin
        state_next  = state_reg;
        frame_ready = 1'b0;
        cmd.load    = 1'b0;
        cmd.op      = ltts_pkg::OP_NONE;
        case (state_reg)
            ltts_pkg::ST_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ltts_pkg::ST_C3X;
                end
            end
            ltts_pkg::ST_C3X:
            begin
                cmd.op     = ltts_pkg::OP_MUL_C3X;
                state_next = ltts_pkg::ST_VDIFF;
            end
            ltts_pkg::ST_VDIFF:
            begin
                cmd.op     = ltts_pkg::OP_VDIFF;
                state_next = ltts_pkg::ST_VLO;
            end
            ltts_pkg::ST_VLO:
            begin
                cmd.op     = ltts_pkg::OP_MUL_VLO;
                state_next = ltts_pkg::ST_VHI;
            end
            ltts_pkg::ST_VHI:
            begin
                cmd.op     = ltts_pkg::OP_MUL_VHI;
                state_next = ltts_pkg::ST_SUMW;
            end
            ltts_pkg::ST_SUMW:
            begin
                cmd.op     = ltts_pkg::OP_SUM_W;
                state_next = ltts_pkg::ST_SUMU;
            end
            ltts_pkg::ST_SUMU:
            begin
                cmd.op     = ltts_pkg::OP_SUM_U;
                state_next = ltts_pkg::ST_QX;
            end
            ltts_pkg::ST_QX:
            begin
                cmd.op     = ltts_pkg::OP_MUL_QX;
                state_next = ltts_pkg::ST_FREQ;
            end
            ltts_pkg::ST_FREQ:
            begin
                cmd.op     = ltts_pkg::OP_FREQ;
                state_next = ltts_pkg::ST_MSTEP;
            end
            ltts_pkg::ST_MSTEP:
            begin
                cmd.op     = ltts_pkg::OP_MUL_STEP;
                state_next = ltts_pkg::ST_STEP;
            end
            ltts_pkg::ST_STEP:
            begin
                cmd.op     = ltts_pkg::OP_STEP;
                state_next = ltts_pkg::ST_GAIN;
            end
            ltts_pkg::ST_GAIN:
            begin
                cmd.op     = ltts_pkg::OP_MUL_GAIN;
                state_next = ltts_pkg::ST_OUT;
            end
            ltts_pkg::ST_OUT:
            begin
                // Hold here while the previous result is still unclaimed.
                if (!status.out_full)
                begin
                    cmd.op     = ltts_pkg::OP_OUT;
                    state_next = ltts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ltts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ltts_datapath.sv -----
// Datapath of the light-to-tone synthesizer: shared multiplier, polynomial,
// phase accumulator, quarter-wave sine table and output register. Depends on ltts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltts_datapath #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ltts_pkg::dp_cmd_t    cmd,
    output ltts_pkg::dp_status_t      status,
    input  wire ltts_pkg::cfg_t       cfg,
    input  wire ltts_pkg::frame_t     frame,
    output ltts_pkg::tone_t           tone,
    output logic                      tone_valid,
    input  wire logic                 tone_ready
);

    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
    localparam int QA_W    = SINE_ADDR_BITS - 1;

    // Constant quarter-wave table, entries 0 through QUARTER inclusive.
    logic [ltts_pkg::SINE_W-1:0] qtab [0:QUARTER];

    for (genvar k = 0; k < QUARTER + 1; k++)
    begin : g_qtab
        localparam logic [ltts_pkg::SINE_W-1:0] QVAL =
            ltts_pkg::quarter_sine(k, SINE_ADDR_BITS);
        assign qtab[k] = QVAL;
    end

    // Per-frame working registers.
    logic [ltts_pkg::XW-1:0]       x_reg;
    logic                          over_reg;
    logic                          eob_reg;
    logic [ltts_pkg::PROD_W-1:0]   prod_reg;
    logic [ltts_pkg::V_W-1:0]      v_reg;
    logic                          vneg_reg;
    logic [ltts_pkg::ACC_W-1:0]    acc_reg;
    logic [ltts_pkg::Q_W-1:0]      q_reg;
    logic [QA_W-1:0]               qaddr_reg;
    logic                          neg_reg;
    logic [ltts_pkg::SINE_W-1:0]   qs_reg;
    ltts_pkg::tone_t               tone_reg;

    // Architectural state.
    logic [ltts_pkg::FREQ_W-1:0]   freq_reg;
    logic [ltts_pkg::FREQ_W-1:0]   freq_next;
    logic [PHASE_BITS-1:0]         step_reg;
    logic [PHASE_BITS-1:0]         step_next;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [PHASE_BITS-1:0]         phase_next;
    logic                          tone_valid_reg;
    logic                          tone_valid_next;

    // Combinational intermediates.
    logic [ltts_pkg::C3_W-1:0]     c3;
    logic [ltts_pkg::C2_W-1:0]     c2;
    logic [ltts_pkg::C1_W-1:0]     c1;
    logic [ltts_pkg::LUX_W-1:0]    limit;
    logic                          lux_over;
    logic [SINE_ADDR_BITS-1:0]     sine_idx;
    logic [1:0]                    quad;
    logic [SINE_ADDR_BITS-3:0]     quad_off;
    logic [QA_W-1:0]               qaddr_next;
    logic [ltts_pkg::MUL_A_W-1:0]  mul_a;
    logic [ltts_pkg::MUL_B_W-1:0]  mul_b;
    logic                          mul_en;
    logic [ltts_pkg::PROD_W-1:0]   mul_prod;
    logic [ltts_pkg::V_W-1:0]      v_low;
    logic [ltts_pkg::V_W-1:0]      c2_ext;
    logic                          vneg_next;
    logic [ltts_pkg::V_W-1:0]      v_next;
    logic [ltts_pkg::ACC_W-1:0]    acc_sum;
    logic [ltts_pkg::U_W-1:0]      c1_ext;
    logic [ltts_pkg::U_W-1:0]      acc_ext;
    logic [ltts_pkg::U_W-1:0]      u_val;
    logic [ltts_pkg::Q_W-1:0]      q_next;
    logic [ltts_pkg::PSUM_W-1:0]   poly_sum;
    logic [ltts_pkg::POLY_W-1:0]   poly;
    logic [ltts_pkg::FSUM_W-1:0]   freq_sum;
    logic [ltts_pkg::GSUM_W-1:0]   gain_sum;
    logic [ltts_pkg::SAMPLE_W-1:0] mag;
    logic [ltts_pkg::SAMPLE_W-1:0] sample_next;
    ltts_pkg::tone_t               tone_next;

    // Coefficients and lux limit of the selected curve.
    always_comb
    begin
        if (cfg.outdoor_mode)
        begin
            c3    = ltts_pkg::OUT_C3;
            c2    = ltts_pkg::OUT_C2;
            c1    = ltts_pkg::OUT_C1;
            limit = ltts_pkg::OUT_LIMIT;
        end
        else
        begin
            c3    = ltts_pkg::IN_C3;
            c2    = ltts_pkg::IN_C2;
            c1    = ltts_pkg::IN_C1;
            limit = ltts_pkg::IN_LIMIT;
        end
    end

    assign lux_over = frame.lux > limit;

    // Table address from the top phase bits, folded into the first quarter.
    assign sine_idx   = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    assign quad       = sine_idx[SINE_ADDR_BITS-1 -: 2];
    assign quad_off   = sine_idx[SINE_ADDR_BITS-3:0];
    assign qaddr_next = quad[0] ? (QA_W'(QUARTER) - QA_W'(quad_off)) : QA_W'(quad_off);

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            ltts_pkg::OP_MUL_C3X:
            begin
                mul_a = ltts_pkg::MUL_A_W'(c3);
                mul_b = ltts_pkg::MUL_B_W'(x_reg);
            end
            ltts_pkg::OP_MUL_VLO:
            begin
                mul_a = ltts_pkg::MUL_A_W'(v_reg[ltts_pkg::VLO_W-1:0]);
                mul_b = ltts_pkg::MUL_B_W'(x_reg);
            end
            ltts_pkg::OP_MUL_VHI:
            begin
                mul_a = ltts_pkg::MUL_A_W'(v_reg[ltts_pkg::V_W-1:ltts_pkg::VLO_W]);
                mul_b = ltts_pkg::MUL_B_W'(x_reg);
            end
            ltts_pkg::OP_MUL_QX:
            begin
                mul_a = q_reg;
                mul_b = ltts_pkg::MUL_B_W'(x_reg);
            end
            ltts_pkg::OP_MUL_STEP:
            begin
                mul_a = ltts_pkg::MUL_A_W'(freq_reg);
                mul_b = cfg.phase_scale;
            end
            ltts_pkg::OP_MUL_GAIN:
            begin
                mul_a = ltts_pkg::MUL_A_W'(qs_reg);
                mul_b = ltts_pkg::MUL_B_W'(cfg.amplitude);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Middle term magnitude and sign: c3*lux - c2.
    assign v_low     = prod_reg[ltts_pkg::V_W-1:0];
    assign c2_ext    = ltts_pkg::V_W'(c2);
    assign vneg_next = v_low < c2_ext;
    assign v_next    = vneg_next ? (c2_ext - v_low) : (v_low - c2_ext);

    // Recombine the split product of the middle term with lux.
    assign acc_sum = {prod_reg[ltts_pkg::ACC_W-ltts_pkg::VLO_W-1:0],
                      {ltts_pkg::VLO_W{1'b0}}} + acc_reg;

    // Add to c1, clamp at zero, keep the quadratic part shifted down.
    assign c1_ext  = ltts_pkg::U_W'(c1);
    assign acc_ext = ltts_pkg::U_W'(acc_reg);
    always_comb
    begin
        if (vneg_reg)
        begin
            u_val = (acc_ext > c1_ext) ? '0 : (c1_ext - acc_ext);
        end
        else
        begin
            u_val = c1_ext + acc_ext;
        end
    end
    assign q_next = u_val[ltts_pkg::U_SHIFT +: ltts_pkg::Q_W];

    // Round the polynomial to Q14.8, add the offset, saturate or take the ceiling.
    assign poly_sum = prod_reg[ltts_pkg::PSUM_W-1:0]
                      + ltts_pkg::PSUM_W'(1 << (ltts_pkg::POLY_SHIFT - 1));
    assign poly     = poly_sum[ltts_pkg::PSUM_W-1:ltts_pkg::POLY_SHIFT];
    assign freq_sum = ltts_pkg::FSUM_W'(poly) + ltts_pkg::FSUM_W'(cfg.base_freq);
    always_comb
    begin
        freq_next = freq_reg;
        if (cmd.op == ltts_pkg::OP_FREQ)
        begin
            if (over_reg)
            begin
                freq_next = cfg.ceiling_freq;
            end
            else if (freq_sum > ltts_pkg::FSUM_W'(ltts_pkg::FREQ_MAX))
            begin
                freq_next = ltts_pkg::FREQ_MAX;
            end
            else
            begin
                freq_next = freq_sum[ltts_pkg::FREQ_W-1:0];
            end
        end
    end

    // Phase increment is the top of the 48-bit frequency product.
    assign step_next = (cmd.op == ltts_pkg::OP_STEP) ?
                       prod_reg[ltts_pkg::STEP_TOP -: PHASE_BITS] : step_reg;

    // Gain with symmetric rounding, then the sign of the half wave.
    assign gain_sum    = prod_reg[ltts_pkg::GSUM_W-1:0]
                         + ltts_pkg::GSUM_W'(1 << (ltts_pkg::GAIN_SHIFT - 1));
    assign mag         = gain_sum[ltts_pkg::GSUM_W-1:ltts_pkg::GAIN_SHIFT];
    always_comb
    begin
        if (!cfg.wave_enable)
        begin
            sample_next = '0;
        end
        else if (neg_reg)
        begin
            sample_next = ltts_pkg::SAMPLE_W'(0) - mag;
        end
        else
        begin
            sample_next = mag;
        end
    end

    always_comb
    begin
        tone_next.sample        = sample_next;
        tone_next.tone_freq     = freq_reg;
        tone_next.last_in_block = eob_reg;
    end

    // The phase advances only while the tone is enabled.
    assign phase_next = (cmd.op == ltts_pkg::OP_OUT && cfg.wave_enable) ?
                        (phase_reg + step_reg) : phase_reg;

    // Output register valid flag.
    always_comb
    begin
        tone_valid_next = tone_valid_reg;
        if (cmd.op == ltts_pkg::OP_OUT)
        begin
            tone_valid_next = 1'b1;
        end
        else if (tone_ready)
        begin
            tone_valid_next = 1'b0;
        end
    end

    // State and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg       <= '0;
            step_reg       <= '0;
            phase_reg      <= '0;
            tone_valid_reg <= 1'b0;
        end
        else
        begin
            freq_reg       <= freq_next;
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            tone_valid_reg <= tone_valid_next;
        end
    end

    // Working registers, loaded by the step that owns them.
    always_ff @(posedge clk)
    begin
        qs_reg <= qtab[qaddr_reg];
        if (cmd.load)
        begin
            x_reg     <= frame.lux[ltts_pkg::XW-1:0];
            over_reg  <= lux_over;
            eob_reg   <= frame.end_of_block;
            qaddr_reg <= qaddr_next;
            neg_reg   <= quad[1];
        end
        if (mul_en)
        begin
            prod_reg <= mul_prod;
        end
        if (cmd.op == ltts_pkg::OP_VDIFF)
        begin
            v_reg    <= v_next;
            vneg_reg <= vneg_next;
        end
        if (cmd.op == ltts_pkg::OP_MUL_VHI)
        begin
            acc_reg <= prod_reg[ltts_pkg::ACC_W-1:0];
        end
        else if (cmd.op == ltts_pkg::OP_SUM_W)
        begin
            acc_reg <= acc_sum;
        end
        if (cmd.op == ltts_pkg::OP_SUM_U)
        begin
            q_reg <= q_next;
        end
        if (cmd.op == ltts_pkg::OP_OUT)
        begin
            tone_reg <= tone_next;
        end
    end

    assign status.out_full = tone_valid_reg && !tone_ready;
    assign tone            = tone_reg;
    assign tone_valid      = tone_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/ltts_checker.sv -----
// Port-level checker for the light-to-tone synthesizer, bound to the top level.
// Depends on ltts_pkg and the assertion macros in light_to_tone_sine_synth_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "light_to_tone_sine_synth_assert.svh"

module ltts_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             frame_valid,
    input wire logic             frame_ready,
    input wire logic             tone_valid,
    input wire logic             tone_ready,
    input wire ltts_pkg::tone_t  tone
);

    // A stalled result keeps its request and payload.
    `LTTS_ASSERT_NEXT(a_tone_hold, tone_valid && !tone_ready, tone_valid && $stable(tone), "tone request dropped or changed while stalled")

    // After a frame is taken the block is busy with it.
    `LTTS_ASSERT_NEXT(a_busy_after_accept, frame_valid && frame_ready, !frame_ready, "frame taken while previous frame in progress")

    // A result never appears right after its frame was taken.
    `LTTS_ASSERT_NEXT(a_no_instant_result, frame_valid && frame_ready, !$rose(tone_valid), "result appeared too early")

    // A new result means the block has just finished and is idle again.
    `LTTS_ASSERT_NOW(a_idle_on_result, $rose(tone_valid), frame_ready, "block not idle after finishing a frame")

endmodule

bind light_to_tone_sine_synth ltts_checker u_ltts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .tone_valid  (tone_valid),
    .tone_ready  (tone_ready),
    .tone        (tone)
);

`default_nettype wire

// ----- tb/tone_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the light-to-tone synthesizer: watches the frame, tone and register ports,
// predicts each tone from its own oscillator state and compares it field by field.
// Depends on ltts_pkg for the payload types, register indexes and curve constants.
module tone_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             frame_valid,
    input  logic                             frame_ready,
    input  ltts_pkg::frame_t                 frame,
    input  logic                             tone_valid,
    input  logic                             tone_ready,
    input  ltts_pkg::tone_t                  tone,
    input  logic                             cfg_we,
    input  logic [ltts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ltts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               pending
);

    import ltts_pkg::*;

    localparam int ADDR_BITS = 10;
    localparam int QUARTER   = 1 << (ADDR_BITS - 2);

    // Register copy and oscillator state of the prediction.
    cfg_t              regs;
    logic [31:0]       osc_phase;
    logic [31:0]       osc_step;
    logic [FREQ_W-1:0] osc_freq;
    logic [SINE_W-1:0] quarter_wave [0:QUARTER];
    tone_t             tones_due [$];
    int                fails;

    // One quarter-wave entry: Taylor series of sin in Q2.30, rounded to Q1.15.
    function automatic logic [SINE_W-1:0] sine_entry(input int q);
        longint angle;
        longint angle_sq;
        longint term;
        longint sum;
        longint rounded;
        int     n;
        angle = (longint'(q) * TWO_PI_Q30 + longint'(QUARTER * 2)) >>> ADDR_BITS;
        angle_sq = (angle * angle) >>> 30;
        term = angle;
        sum = angle;
        for (n = 1; n <= 8; n++)
        begin
            term = ((term * angle_sq) >>> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        rounded = (sum * 64'sd32767 + (longint'(1) <<< 29)) >>> 30;
        return rounded[SINE_W-1:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= QUARTER; k++)
            quarter_wave[k] = sine_entry(k);
    end

    // Cubic curve in Horner form at scale 2^52, plus base offset, saturated to 20 bits.
    function automatic logic [FREQ_W-1:0] curve_freq(input logic [LUX_W-1:0] lux);
        longint            x;
        longint            c1;
        longint            c2;
        longint            c3;
        longint            u;
        longint unsigned   p;
        longint unsigned   f;
        x  = longint'(lux);
        c3 = regs.outdoor_mode ? longint'(OUT_C3) : longint'(IN_C3);
        c2 = regs.outdoor_mode ? longint'(OUT_C2) : longint'(IN_C2);
        c1 = regs.outdoor_mode ? longint'(OUT_C1) : longint'(IN_C1);
        u = (c3 * x - c2) * x + c1;
        if (u < 0)
            u = 0;
        p = (u >>> 20) * x;
        f = ((p + 64'd8388608) >> 24) + longint'(regs.base_freq);
        if (f > longint'(FREQ_MAX))
            f = longint'(FREQ_MAX);
        return f[FREQ_W-1:0];
    endfunction

    // Advance the oscillator by one frame and return the tone it produces.
    function automatic tone_t next_tone(input frame_t req);
        tone_t               t;
        logic [LUX_W-1:0]    limit;
        logic [47:0]         prod;
        logic [ADDR_BITS-1:0] idx;
        logic [8:0]          r;
        logic [30:0]         scaled;
        logic [SAMPLE_W-1:0] mag;
        limit = regs.outdoor_mode ? OUT_LIMIT : IN_LIMIT;
        if (req.lux > limit)
            osc_freq = regs.ceiling_freq;
        else
            osc_freq = curve_freq(req.lux);
        prod = {28'd0, osc_freq} * {20'd0, regs.phase_scale};
        osc_step = prod[47:16];
        t.sample = '0;
        if (regs.wave_enable)
        begin
            // Fold the top address bits onto the quarter table, mirror and negate.
            idx = osc_phase[31:32-ADDR_BITS];
            if (idx[ADDR_BITS-2])
                r = 9'(QUARTER) - {1'b0, idx[ADDR_BITS-3:0]};
            else
                r = {1'b0, idx[ADDR_BITS-3:0]};
            scaled = {16'd0, quarter_wave[r]} * {16'd0, regs.amplitude} + 31'd16384;
            mag = scaled[30:15];
            t.sample = idx[ADDR_BITS-1] ? (~mag + 16'd1) : mag;
            osc_phase = osc_phase + osc_step;
        end
        t.tone_freq = osc_freq;
        t.last_in_block = req.end_of_block;
        return t;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        if (fails < 10)
            $display("%t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        fails++;
    endtask

    // Register writes, result checks and new predictions, all at the rising edge.
    always @(posedge clk)
    begin
        tone_t got;
        tone_t want;
        if (!rst_n)
        begin
            regs.outdoor_mode = 1'b0;
            regs.base_freq    = BASE_FREQ_RST;
            regs.ceiling_freq = CEILING_FREQ_RST;
            regs.phase_scale  = PHASE_SCALE_RST;
            regs.amplitude    = AMPLITUDE_RST;
            regs.wave_enable  = 1'b0;
            osc_phase = '0;
            osc_step  = '0;
            osc_freq  = '0;
            tones_due.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OUTDOOR_MODE: regs.outdoor_mode = cfg_data[0];
                    REG_BASE_FREQ:    regs.base_freq    = cfg_data[FREQ_W-1:0];
                    REG_CEILING_FREQ: regs.ceiling_freq = cfg_data[FREQ_W-1:0];
                    REG_PHASE_SCALE:  regs.phase_scale  = cfg_data[SCALE_W-1:0];
                    REG_AMPLITUDE:    regs.amplitude    = cfg_data[AMP_W-1:0];
                    REG_WAVE_ENABLE:  regs.wave_enable  = cfg_data[0];
                    default:          ;
                endcase
            end
            // Compare a delivered tone against the oldest prediction.
            if (tone_valid && tone_ready)
            begin
                got = tone;
                if (tones_due.size() == 0)
                begin
                    if (fails < 10)
                        $display("%t: tone request with no prediction waiting", $realtime);
                    fails++;
                end
                else
                begin
                    want = tones_due.pop_front();
                    if (got.sample !== want.sample)
                        note_mismatch("sample", want.sample, got.sample);
                    if (got.tone_freq !== want.tone_freq)
                        note_mismatch("tone_freq", want.tone_freq, got.tone_freq);
                    if (got.last_in_block !== want.last_in_block)
                        note_mismatch("last_in_block", want.last_in_block, got.last_in_block);
                end
            end
            if (frame_valid && frame_ready)
                tones_due.push_back(next_tone(frame));
        end
        mismatches <= fails;
        pending <= tones_due.size();
    end

endmodule

// ----- tb/tb_light_to_tone_sine_synth.sv -----
`timescale 1ns / 1ps
// Top of the light-to-tone synthesizer testbench: clock, reset, frame and register stimulus,
// receiver stalls and the verdict. Depends on ltts_pkg, the block and tone_checker.
module tb_light_to_tone_sine_synth;

    import ltts_pkg::*;

    localparam int RUN_LIMIT  = 500000;
    localparam int DRAIN_WAIT = 20;
    localparam int PHASES     = 8;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   frame_valid;
    logic                   frame_ready;
    frame_t                 frame_req;
    logic                   tone_valid;
    logic                   tone_ready;
    tone_t                  tone_rsp;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;
    int                     burst_left;
    logic                   cur_outdoor;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    light_to_tone_sine_synth dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame_req),
        .tone_valid  (tone_valid),
        .tone_ready  (tone_ready),
        .tone        (tone_rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tone_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame_req),
        .tone_valid  (tone_valid),
        .tone_ready  (tone_ready),
        .tone        (tone_rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // Offer one frame request at the falling edge and hold it until accepted.
    task automatic send_frame(input logic [LUX_W-1:0] lux, input logic eob);
        frame_valid = 1'b1;
        frame_req.lux = lux;
        frame_req.end_of_block = eob;
        do
            @(posedge clk);
        while (!frame_ready);
        @(negedge clk);
    endtask

    // Bursts of back-to-back requests separated by random gaps with junk payload.
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            frame_valid = 1'b0;
            frame_req = frame_t'($urandom);
            repeat ($urandom_range(1, 20)) @(negedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 250);
            else
                burst_left = $urandom_range(0, 12);
        end
    endtask

    // Wait until every predicted tone has arrived and the block has gone quiet.
    task automatic settle();
        frame_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Single-bit registers get random upper data bits, which must be ignored.
    function automatic logic [CFG_DATA_W-1:0] flag_data(input logic bit_value);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[0] = bit_value;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_freq(input logic [FREQ_W-1:0] rst_value);
        case ($urandom_range(0, 4))
            0: return CFG_DATA_W'($urandom_range(0, 200000));
            1: return CFG_DATA_W'($urandom);
            2: return CFG_DATA_W'(FREQ_MAX - $urandom_range(0, 300000));
            3: return CFG_DATA_W'(rst_value);
            default: return CFG_DATA_W'($urandom_range(0, 4000));
        endcase
    endfunction

    // Random register set for one phase; the first phase takes zero base and scale, the least gain and the top ceiling.
    task automatic configure_phase(input int ph);
        logic [CFG_DATA_W-1:0] scale;
        logic [CFG_DATA_W-1:0] amp;
        case ($urandom_range(0, 3))
            0: scale = '0;
            1: scale = CFG_DATA_W'(28'hFFFFFFF);
            2: scale = CFG_DATA_W'(PHASE_SCALE_RST);
            default: scale = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: amp = '0;
            1: amp = CFG_DATA_W'(15'h7FFF);
            default: amp = CFG_DATA_W'($urandom);
        endcase
        cur_outdoor = $urandom_range(0, 1);
        if (ph == 0)
        begin
            cur_outdoor = 1'b0;
            write_reg(REG_OUTDOOR_MODE, flag_data(cur_outdoor));
            write_reg(REG_BASE_FREQ, '0);
            write_reg(REG_CEILING_FREQ, CFG_DATA_W'(FREQ_MAX));
            write_reg(REG_PHASE_SCALE, '0);
            write_reg(REG_AMPLITUDE, CFG_DATA_W'(1));
            write_reg(REG_WAVE_ENABLE, flag_data(1'b1));
        end
        else
        begin
            write_reg(REG_OUTDOOR_MODE, flag_data(cur_outdoor));
            write_reg(REG_BASE_FREQ, pick_freq(BASE_FREQ_RST));
            write_reg(REG_CEILING_FREQ, pick_freq(CEILING_FREQ_RST));
            write_reg(REG_PHASE_SCALE, scale);
            write_reg(REG_AMPLITUDE, amp);
            write_reg(REG_WAVE_ENABLE, flag_data($urandom_range(0, 4) != 0));
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          CFG_DATA_W'($urandom));
        end
    endtask

    // Mostly readings on the curve, some right around the limit, some anywhere.
    function automatic logic [LUX_W-1:0] rand_lux();
        int limit;
        limit = cur_outdoor ? int'(OUT_LIMIT) : int'(IN_LIMIT);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return LUX_W'($urandom_range(0, limit));
            6: return LUX_W'(limit + $urandom_range(0, 6) - 3);
            7, 8: return LUX_W'($urandom);
            default: return LUX_W'($urandom_range(0, 20));
        endcase
    endfunction

    // Receiver: changing stall patterns, with a long hold-off now and then so the
    // block fills up and has to refuse new requests.
    initial
    begin
        int       rx_cycle;
        int       hold_left;
        int       mode_left;
        rx_mode_t mode;
        tone_ready = 1'b0;
        rx_cycle = 0;
        hold_left = 0;
        mode_left = 0;
        mode = RX_OPEN;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (hold_left == 0 && rx_cycle % 4000 == 2500)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                tone_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   tone_ready = 1'b1;
                    RX_COIN:   tone_ready = $urandom_range(0, 1);
                    RX_SPARSE: tone_ready = (rx_cycle % 4 == 0);
                    default:   tone_ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("tb_light_to_tone_sine_synth: errors");
        $finish;
    end

    // Stimulus: directed corners first, then randomly configured phases.
    initial
    begin
        int ph;
        int n;
        int count;
        rst_n = 1'b0;
        frame_valid = 1'b0;
        frame_req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        cur_outdoor = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: tone disabled, so silence while the frequency still follows lux.
        send_frame(16'd0, 1'b1);
        pace();
        send_frame(IN_LIMIT, 1'b0);
        pace();
        send_frame(16'hFFFF, 1'b1);
        settle();

        // Full gain and the largest scale on the indoor curve, around its limit.
        write_reg(REG_WAVE_ENABLE, CFG_DATA_W'(1));
        write_reg(REG_AMPLITUDE, CFG_DATA_W'(15'h7FFF));
        write_reg(REG_PHASE_SCALE, CFG_DATA_W'(28'hFFFFFFF));
        send_frame(16'd0, 1'b0);
        pace();
        send_frame(16'd1, 1'b1);
        pace();
        send_frame(IN_LIMIT - 16'd1, 1'b0);
        pace();
        send_frame(IN_LIMIT, 1'b1);
        pace();
        send_frame(IN_LIMIT + 16'd1, 1'b0);
        pace();
        send_frame(16'hFFFF, 1'b1);
        settle();

        // Outdoor curve; the upper data bits of the mode write must be dropped.
        write_reg(REG_OUTDOOR_MODE, CFG_DATA_W'(28'hFFFFFFF));
        cur_outdoor = 1'b1;
        send_frame(OUT_LIMIT - 16'd1, 1'b0);
        pace();
        send_frame(OUT_LIMIT, 1'b1);
        pace();
        send_frame(OUT_LIMIT + 16'd1, 1'b0);
        pace();
        send_frame(16'hFFFF, 1'b1);
        settle();

        // Base at full scale saturates the frequency; a zero ceiling above the limit.
        write_reg(REG_BASE_FREQ, CFG_DATA_W'(FREQ_MAX));
        write_reg(REG_CEILING_FREQ, '0);
        send_frame(16'd0, 1'b0);
        pace();
        send_frame(OUT_LIMIT, 1'b1);
        pace();
        send_frame(OUT_LIMIT + 16'd1, 1'b0);
        settle();

        // Zero gain, then writes to indexes that hold no register.
        write_reg(REG_AMPLITUDE, '0);
        write_reg(REG_SPARE_LO, CFG_DATA_W'(28'hFFFFFFF));
        write_reg(REG_SPARE_HI, CFG_DATA_W'(28'hFFFFFFF));
        send_frame(16'd3000, 1'b1);
        pace();
        send_frame(16'd100, 1'b0);
        pace();
        send_frame(16'd20000, 1'b1);
        settle();

        // Enable written with only its low bit clear: silence and a held phase.
        write_reg(REG_AMPLITUDE, CFG_DATA_W'(AMPLITUDE_RST));
        write_reg(REG_WAVE_ENABLE, CFG_DATA_W'(28'hFFFFFFE));
        send_frame(16'd200, 1'b0);
        pace();
        send_frame(16'd300, 1'b1);

        // Random phases, each with every register rewritten while the block is idle.
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            configure_phase(ph);
            count = $urandom_range(170, 220);
            for (n = 0; n < count; n++)
            begin
                send_frame(rand_lux(), $urandom_range(0, 1));
                pace();
            end
        end

        frame_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb_light_to_tone_sine_synth: clean");
        else
            $display("tb_light_to_tone_sine_synth: errors");
        $finish;
    end

endmodule
